// File: hw/rtl/priority_deadline_drop_fifo_macros.svh
// Assertion helpers for the drop FIFO; all checks are on clk and disabled in reset.
`ifndef PRIORITY_DEADLINE_DROP_FIFO_MACROS_SVH
`define PRIORITY_DEADLINE_DROP_FIFO_MACROS_SVH

// Same-cycle implication.
`define PDDF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PDDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pddf_pkg.sv
`timescale 1ns / 1ps
package pddf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 1024;

  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PROD_W   = TIME_W + PRIO_W;

  localparam logic [TIME_W-1:0]    DELAY_RST  = '0;
  localparam logic [PRIO_W-1:0]    LEVELS_RST = 8'd1;
  localparam logic [CNT_OUT_W-1:0] MAXPKT_RST = 11'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXPKT = 2'd2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                tag;
    logic [PRIO_W-1:0]   prio;
    logic [TIME_W-1:0]   arrival;
  } entry_t;

  typedef struct packed {
    logic mul_en;
    logic keep_first;
  } mul_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_HEAD,
    ST_READ,
    ST_MULB,
    ST_CMP,
    ST_FIN
  } state_t;

endpackage

// File: hw/rtl/priority_deadline_drop_fifo.sv
`timescale 1ns / 1ps
// Enqueue: ENQ writes the entry if there is room, then FIN raises done. Dequeue: HEAD reads
// the head entry, or goes to FIN on an empty queue; an untagged head is delivered from READ,
// a tagged one is checked (read, two passes of the shared multiplier, compare) and, if stale,
// dropped before a return to HEAD. One operation at a time: busy is high from the accepting
// edge through done, so the next transfer is accepted in the cycle after done at the earliest.
// Synchronous reset restores pointers, count and settings; the entry store is not cleared.
`include "priority_deadline_drop_fifo_macros.svh"
module priority_deadline_drop_fifo
  import pddf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  output logic                  done,
  input  logic                  operation,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic [HANDLE_W-1:0]   packet_handle,
  input  logic                  tagged_req,
  input  logic [PRIO_W-1:0]     priority_req,
  output logic                  enqueue_accepted,
  output logic                  out_valid,
  output logic [HANDLE_W-1:0]   out_handle,
  output logic                  out_tagged,
  output logic [PRIO_W-1:0]     out_priority,
  output logic [CNT_OUT_W-1:0]  stale_dropped,
  output logic [CNT_OUT_W-1:0]  occupancy,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  state_t state, state_next;

  logic [TIME_W-1:0]    delay_limit;
  logic [PRIO_W-1:0]    levels;
  logic [CNT_OUT_W-1:0] max_packets;

  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count;
  logic [CMP_W-1:0] count_ext;

  logic                op_q;
  logic [TIME_W-1:0]   now_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                tag_q;
  logic [PRIO_W-1:0]   prio_q;

  logic                 res_acc, res_valid, res_tagged;
  logic [HANDLE_W-1:0]  res_handle;
  logic [PRIO_W-1:0]    res_prio;
  logic [CNT_OUT_W-1:0] dropped;

  entry_t   wr_entry, rd_entry;
  logic     wr_en, rd_en;
  mul_ctl_t mul_ctl;
  logic [TIME_W-1:0] mul_a;
  logic [PRIO_W-1:0] mul_b;
  logic     exceeds;
  logic     accept, enq_ok, special, stale, deliver, drop_one;
  logic [TIME_W-1:0] age;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign count_ext = CMP_W'(count);
  assign enq_ok    = (count_ext < CMP_W'(max_packets)) && (count != CNT_FULL);
  assign age       = now_q - rd_entry.arrival;
  assign special   = (levels == '0) || (rd_entry.prio > levels);
  assign stale     = special ? (age != '0) : exceeds;

  assign wr_entry = '{handle: handle_q, tag: tag_q, prio: prio_q, arrival: now_q};

  pddf_mem #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (PTR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (head),
    .rd_data (rd_entry)
  );

  pddf_mul_unit u_mul (
    .clk     (clk),
    .ctl     (mul_ctl),
    .a       (mul_a),
    .b       (mul_b),
    .exceeds (exceeds)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = (operation == OP_ENQ) ? ST_ENQ : ST_HEAD;
      ST_ENQ:  state_next = ST_FIN;
      ST_HEAD: state_next = (count == '0) ? ST_FIN : ST_READ;
      ST_READ: state_next = rd_entry.tag ? ST_MULB : ST_FIN;
      ST_MULB: state_next = ST_CMP;
      ST_CMP:  state_next = stale ? ST_HEAD : ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    done     = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    mul_ctl  = '0;
    mul_a    = delay_limit;
    mul_b    = levels - rd_entry.prio;
    deliver  = 1'b0;
    drop_one = 1'b0;
    unique case (state)
      ST_IDLE: busy = 1'b0;
      ST_ENQ:  wr_en = enq_ok;
      ST_HEAD: rd_en = (count != '0);
      ST_READ: begin
        mul_ctl.mul_en = 1'b1;
        deliver = !rd_entry.tag;
      end
      ST_MULB: begin
        mul_a = age;
        mul_b = levels;
        mul_ctl.mul_en = 1'b1;
        mul_ctl.keep_first = 1'b1;
      end
      ST_CMP: begin
        drop_one = stale;
        deliver  = !stale;
      end
      ST_FIN:  done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      delay_limit <= DELAY_RST;
      levels      <= LEVELS_RST;
      max_packets <= MAXPKT_RST;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DELAY:  delay_limit <= cfg_data;
          CFG_LEVELS: levels      <= cfg_data[PRIO_W-1:0];
          CFG_MAXPKT: max_packets <= cfg_data[CNT_OUT_W-1:0];
          default: ;
        endcase
      end
      if (wr_en) begin
        tail  <= (tail == PTR_LAST) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end
      if (rd_en) begin
        head  <= (head == PTR_LAST) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
    end
  end

  // operation fields and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= operation;
      now_q      <= now_ms;
      handle_q   <= packet_handle;
      tag_q      <= tagged_req;
      prio_q     <= priority_req;
      res_acc    <= 1'b0;
      res_valid  <= 1'b0;
      res_handle <= '0;
      res_tagged <= 1'b0;
      res_prio   <= '0;
      dropped    <= '0;
    end else begin
      if (wr_en) res_acc <= 1'b1;
      if (drop_one) dropped <= dropped + 1'b1;
      if (deliver) begin
        res_valid  <= 1'b1;
        res_handle <= rd_entry.handle;
        res_tagged <= rd_entry.tag;
        res_prio   <= rd_entry.prio;
      end
    end
  end

  assign enqueue_accepted = res_acc;
  assign out_valid        = res_valid;
  assign out_handle       = res_handle;
  assign out_tagged       = res_tagged;
  assign out_priority     = res_prio;
  assign stale_dropped    = dropped;
  assign occupancy        = count_ext[CNT_OUT_W-1:0];

  `PDDF_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_FULL, "entry count above depth")
  `PDDF_ASSERT_IMPL(a_read_nonempty, rd_en, count != '0, "head read from empty queue")
  `PDDF_ASSERT_IMPL(a_one_kind, done, !(res_acc && res_valid), "enqueue and delivery in one result")
  `PDDF_ASSERT_IMPL(a_enq_only, wr_en, op_q == OP_ENQ, "store written outside an enqueue")
  `PDDF_ASSERT_NEXT(a_busy_after, accept, busy, "not busy after transfer")

endmodule

// File: hw/rtl/pddf_mem.sv
`timescale 1ns / 1ps
module pddf_mem
  import pddf_pkg::*;
#(
  parameter int unsigned DEPTH  = QUEUE_DEPTH_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/pddf_mul_unit.sv
`timescale 1ns / 1ps
module pddf_mul_unit
  import pddf_pkg::*;
(
  input  logic              clk,
  input  mul_ctl_t          ctl,
  input  logic [TIME_W-1:0] a,
  input  logic [PRIO_W-1:0] b,
  output logic              exceeds
);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] first;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
    if (ctl.keep_first) begin
      first <= prod;
    end
  end

  // first = limit * (L - p), prod = age * L; age exceeds floor(first / L) iff first < prod
  assign exceeds = first < prod;

endmodule
